FILE: src/mbx_pkg.sv
// Package for the IPC mailbox register block: beat types, action codes,
// register map constants and control register bit positions. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mbx_pkg;

    // Action codes carried in the command beat.
    localparam logic [2:0] ACT_READ     = 3'd0;
    localparam logic [2:0] ACT_WRITE    = 3'd1;
    localparam logic [2:0] ACT_COMPLETE = 3'd2;
    localparam logic [2:0] ACT_RAISE    = 3'd3;
    localparam logic [2:0] ACT_CLEAR    = 3'd4;

    // Register map.
    localparam logic [31:0] MB_BASE     = 32'h0D80_0000;
    localparam logic [31:0] OFS_PPCMSG  = 32'h000;
    localparam logic [31:0] OFS_PPCCTRL = 32'h004;
    localparam logic [31:0] OFS_ARMMSG  = 32'h008;
    localparam logic [31:0] OFS_ARMCTRL = 32'h00C;
    localparam logic [31:0] OFS_TIMER   = 32'h010;
    localparam logic [31:0] OFS_ALARM   = 32'h014;
    localparam logic [31:0] OFS_PPCFLAG = 32'h030;
    localparam logic [31:0] OFS_PPCMASK = 32'h034;
    localparam logic [31:0] OFS_ARMFLAG = 32'h038;
    localparam logic [31:0] OFS_ARMMASK = 32'h03C;
    localparam logic [31:0] OFS_COMPAT  = 32'h180;
    localparam logic [31:0] OFS_BOOT    = 32'h18C;
    localparam logic [31:0] OFS_CLOCKS  = 32'h190;
    localparam logic [31:0] OFS_RESETS  = 32'h194;

    // PPC control register bits.
    localparam int BIT_X1  = 0;
    localparam int BIT_Y2  = 1;
    localparam int BIT_Y1  = 2;
    localparam int BIT_X2  = 3;
    localparam int BIT_IY1 = 4;
    localparam int BIT_IY2 = 5;
    localparam logic [5:0] CTRL_RW_MASK = 6'b11_1001;
    localparam logic [5:0] CTRL_W1C_MASK = 6'b00_0110;

    localparam int REPLY_SOURCE = 30;
    localparam int DOORBELL_BIT = 31;

    // Decoded register selection.
    typedef enum logic [3:0] {
        SEL_NONE,
        SEL_PPCMSG,
        SEL_PPCCTRL,
        SEL_ARMMSG,
        SEL_ARMCTRL,
        SEL_TIMER,
        SEL_ALARM,
        SEL_PPCFLAG,
        SEL_PPCMASK,
        SEL_ARMFLAG,
        SEL_ARMMASK,
        SEL_COMPAT,
        SEL_BOOT,
        SEL_CLOCKS,
        SEL_RESETS
    } reg_sel_t;

    // Command beat.
    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] bus_address;
        logic [31:0] write_data;
        logic [5:0]  irq_source;
    } cmd_t;

    // Response beat.
    typedef struct packed {
        logic [31:0] read_data;
        logic        ppc_irq_pending;
    } rsp_t;

endpackage

`default_nettype wire

FILE: src/mbx_decode.sv
// Address decoder for the mailbox register map.
// Depends on mbx_pkg for the map constants and the selection type.
`timescale 1ns / 1ps
`default_nettype none

module mbx_decode (
    input  wire logic [31:0]      bus_address,
    output mbx_pkg::reg_sel_t     sel
);
    import mbx_pkg::*;

    // Compare the full byte address against each register location.
    always_comb
    begin
        case (bus_address)
            MB_BASE + OFS_PPCMSG:  sel = SEL_PPCMSG;
            MB_BASE + OFS_PPCCTRL: sel = SEL_PPCCTRL;
            MB_BASE + OFS_ARMMSG:  sel = SEL_ARMMSG;
            MB_BASE + OFS_ARMCTRL: sel = SEL_ARMCTRL;
            MB_BASE + OFS_TIMER:   sel = SEL_TIMER;
            MB_BASE + OFS_ALARM:   sel = SEL_ALARM;
            MB_BASE + OFS_PPCFLAG: sel = SEL_PPCFLAG;
            MB_BASE + OFS_PPCMASK: sel = SEL_PPCMASK;
            MB_BASE + OFS_ARMFLAG: sel = SEL_ARMFLAG;
            MB_BASE + OFS_ARMMASK: sel = SEL_ARMMASK;
            MB_BASE + OFS_COMPAT:  sel = SEL_COMPAT;
            MB_BASE + OFS_BOOT:    sel = SEL_BOOT;
            MB_BASE + OFS_CLOCKS:  sel = SEL_CLOCKS;
            MB_BASE + OFS_RESETS:  sel = SEL_RESETS;
            default:               sel = SEL_NONE;
        endcase
    end

endmodule

`default_nettype wire

FILE: src/mbx_regs.sv
// Mailbox register file: holds all architectural registers and applies one
// action per cycle when step is high. Depends on mbx_pkg and mbx_decode.
`timescale 1ns / 1ps
`default_nettype none

module mbx_regs (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          step,
    input  mbx_pkg::cmd_t      cmd,
    output mbx_pkg::rsp_t      rsp
);
    import mbx_pkg::*;

    logic [31:0] ppc_message_reg, ppc_message_next;
    logic [5:0]  ppc_control_reg, ppc_control_next;
    logic [31:0] arm_message_reg, arm_message_next;
    logic [31:0] arm_control_reg, arm_control_next;
    logic [31:0] timer_word_reg, timer_word_next;
    logic [31:0] alarm_word_reg, alarm_word_next;
    logic [31:0] ppc_flags_reg, ppc_flags_next;
    logic [31:0] ppc_mask_reg, ppc_mask_next;
    logic [31:0] arm_flags_reg, arm_flags_next;
    logic [31:0] arm_mask_reg, arm_mask_next;
    logic [31:0] compat_word_reg, compat_word_next;
    logic [31:0] boot_word_reg, boot_word_next;
    logic [31:0] clocks_word_reg, clocks_word_next;
    logic [31:0] resets_word_reg, resets_word_next;

    reg_sel_t    sel;
    logic        src_ok;
    logic [31:0] src_bit;
    logic [5:0]  ctrl_written;
    logic [5:0]  ctrl_replied;
    logic [31:0] read_word;

    mbx_decode u_decode (
        .bus_address (cmd.bus_address),
        .sel         (sel)
    );

    assign src_ok   = (cmd.irq_source[5] == 1'b0);
    assign src_bit  = 32'd1 << cmd.irq_source[4:0];

    // Control register write: plain bits take the data, Y bits clear on one.
    assign ctrl_written = ((ppc_control_reg & ~CTRL_RW_MASK)
                           | (cmd.write_data[5:0] & CTRL_RW_MASK))
                          & ~(cmd.write_data[5:0] & CTRL_W1C_MASK);

    // Reply completion: drop X1, raise Y1 and Y2.
    always_comb
    begin
        ctrl_replied = ppc_control_reg;
        ctrl_replied[BIT_X1] = 1'b0;
        ctrl_replied[BIT_Y1] = 1'b1;
        ctrl_replied[BIT_Y2] = 1'b1;
    end

    // Next-state logic for every register.
    always_comb
    begin
        ppc_message_next = ppc_message_reg;
        ppc_control_next = ppc_control_reg;
        arm_message_next = arm_message_reg;
        arm_control_next = arm_control_reg;
        timer_word_next  = timer_word_reg;
        alarm_word_next  = alarm_word_reg;
        ppc_flags_next   = ppc_flags_reg;
        ppc_mask_next    = ppc_mask_reg;
        arm_flags_next   = arm_flags_reg;
        arm_mask_next    = arm_mask_reg;
        compat_word_next = compat_word_reg;
        boot_word_next   = boot_word_reg;
        clocks_word_next = clocks_word_reg;
        resets_word_next = resets_word_reg;

        case (cmd.action)
            ACT_WRITE:
            begin
                case (sel)
                    SEL_PPCMSG:  ppc_message_next = cmd.write_data;
                    SEL_PPCCTRL:
                    begin
                        ppc_control_next = ctrl_written;
                        if (cmd.write_data[BIT_X1])
                        begin
                            arm_flags_next[DOORBELL_BIT] = 1'b1;
                        end
                    end
                    SEL_ARMMSG:  arm_message_next = cmd.write_data;
                    SEL_ARMCTRL: arm_control_next = cmd.write_data;
                    SEL_TIMER:   timer_word_next  = cmd.write_data;
                    SEL_ALARM:   alarm_word_next  = cmd.write_data;
                    SEL_PPCFLAG: ppc_flags_next   = ppc_flags_reg & ~cmd.write_data;
                    SEL_PPCMASK: ppc_mask_next    = cmd.write_data;
                    SEL_ARMFLAG: arm_flags_next   = arm_flags_reg & ~cmd.write_data;
                    SEL_ARMMASK: arm_mask_next    = cmd.write_data;
                    SEL_COMPAT:  compat_word_next = cmd.write_data;
                    SEL_BOOT:    boot_word_next   = cmd.write_data;
                    SEL_CLOCKS:  clocks_word_next = cmd.write_data;
                    SEL_RESETS:  resets_word_next = cmd.write_data;
                    default:     ;
                endcase
            end
            ACT_COMPLETE:
            begin
                ppc_control_next = ctrl_replied;
                if (ctrl_replied[BIT_IY1])
                begin
                    ppc_flags_next[REPLY_SOURCE] = 1'b1;
                end
            end
            ACT_RAISE:
            begin
                if (src_ok)
                begin
                    ppc_flags_next = ppc_flags_reg | src_bit;
                end
            end
            ACT_CLEAR:
            begin
                if (src_ok)
                begin
                    ppc_flags_next = ppc_flags_reg & ~src_bit;
                end
            end
            default: ;
        endcase
    end

    // Read mux over the current register values.
    always_comb
    begin
        case (sel)
            SEL_PPCMSG:  read_word = ppc_message_reg;
            SEL_PPCCTRL: read_word = {26'd0, ppc_control_reg};
            SEL_ARMMSG:  read_word = arm_message_reg;
            SEL_ARMCTRL: read_word = arm_control_reg;
            SEL_TIMER:   read_word = timer_word_reg;
            SEL_ALARM:   read_word = alarm_word_reg;
            SEL_PPCFLAG: read_word = ppc_flags_reg;
            SEL_PPCMASK: read_word = ppc_mask_reg;
            SEL_ARMFLAG: read_word = arm_flags_reg;
            SEL_ARMMASK: read_word = arm_mask_reg;
            SEL_COMPAT:  read_word = compat_word_reg;
            SEL_BOOT:    read_word = boot_word_reg;
            SEL_CLOCKS:  read_word = clocks_word_reg;
            SEL_RESETS:  read_word = resets_word_reg;
            default:     read_word = 32'd0;
        endcase
    end

    // Response for this step; pending reflects the state after the action.
    assign rsp.read_data       = (cmd.action == ACT_READ) ? read_word : 32'd0;
    assign rsp.ppc_irq_pending = |(ppc_flags_next & ppc_mask_next);

    // Register update, one action per step.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ppc_message_reg <= '0;
            ppc_control_reg <= '0;
            arm_message_reg <= '0;
            arm_control_reg <= '0;
            timer_word_reg  <= '0;
            alarm_word_reg  <= '0;
            ppc_flags_reg   <= '0;
            ppc_mask_reg    <= '0;
            arm_flags_reg   <= '0;
            arm_mask_reg    <= '0;
            compat_word_reg <= '0;
            boot_word_reg   <= '0;
            clocks_word_reg <= '0;
            resets_word_reg <= '0;
        end
        else if (step)
        begin
            ppc_message_reg <= ppc_message_next;
            ppc_control_reg <= ppc_control_next;
            arm_message_reg <= arm_message_next;
            arm_control_reg <= arm_control_next;
            timer_word_reg  <= timer_word_next;
            alarm_word_reg  <= alarm_word_next;
            ppc_flags_reg   <= ppc_flags_next;
            ppc_mask_reg    <= ppc_mask_next;
            arm_flags_reg   <= arm_flags_next;
            arm_mask_reg    <= arm_mask_next;
            compat_word_reg <= compat_word_next;
            boot_word_reg   <= boot_word_next;
            clocks_word_reg <= clocks_word_next;
            resets_word_reg <= resets_word_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/ipc_mailbox_irq_registers.sv
// IPC mailbox register block with doorbell and interrupt flags.
// Path: a command beat is taken into the command register, and its
// response is registered in the response register when it advances.
// Throughput: one beat per cycle unless rsp_stall; single-pass update.
// Reset: rst_n clears every mailbox register and both valid flags.
// Depends on mbx_pkg and mbx_regs.
`timescale 1ns / 1ps
`default_nettype none

module ipc_mailbox_irq_registers (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_valid,
    output logic               cmd_stall,
    input  mbx_pkg::cmd_t      cmd,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output mbx_pkg::rsp_t      rsp
);
    import mbx_pkg::*;

    logic cmd_valid_reg;
    cmd_t cmd_reg;
    logic rsp_valid_reg;
    rsp_t rsp_reg;
    rsp_t rsp_next;
    logic advance;

    // The held command moves on when the response register is free or drains.
    assign advance   = cmd_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign cmd_stall = cmd_valid_reg && !advance;

    mbx_regs u_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .cmd   (cmd_reg),
        .rsp   (rsp_next)
    );

    // Command stage valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else if (!cmd_stall)
        begin
            cmd_valid_reg <= cmd_valid;
        end
    end

    // Command stage payload.
    always_ff @(posedge clk)
    begin
        if (cmd_valid && !cmd_stall)
        begin
            cmd_reg <= cmd;
        end
    end

    // Response stage valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // Response stage payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire
